>>> sv/dox_pkg.sv
// ----------------------------------------------------------------------------
// dox_pkg
// Shared constants and types for the DHCP option extractor.
// ----------------------------------------------------------------------------
package dox_pkg;

  localparam int unsigned ADDR_BYTES  = 4;
  localparam int unsigned HEADER_SKIP = 3;
  localparam int unsigned IDX_W       = $clog2(ADDR_BYTES + 1);
  localparam int unsigned FLAGS_W     = 4;

  localparam logic [7:0] TAG_MASK   = 8'd1;
  localparam logic [7:0] TAG_ROUTER = 8'd3;
  localparam logic [7:0] TAG_LEASE  = 8'd51;
  localparam logic [7:0] TAG_SERVER = 8'd54;
  localparam logic [7:0] TAG_END    = 8'hff;

  // found_flags bit positions
  localparam int unsigned FLAG_MASK   = 0;
  localparam int unsigned FLAG_ROUTER = 1;
  localparam int unsigned FLAG_SERVER = 2;
  localparam int unsigned FLAG_LEASE  = 3;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_TAG    = 5'b00010,
    PH_LEN    = 5'b00100,
    PH_VALUE  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

endpackage

>>> sv/dhcp_option_extractor.sv
// ----------------------------------------------------------------------------
// dhcp_option_extractor
// Walks a DHCP options field one byte per item and reports captured options.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with opt_byte_i and
// start_of_options_i. Set start_of_options_i on the first options byte; it
// restarts the parse (captured values are kept, found flags are cleared).
// Offset 2 is kept as the message type; tag/length/value triples follow.
// Output channel: out_valid_o / out_stall_i. One item is produced on the
// end tag with the message type, mask, router, server id, lease and flags.
// Bytes after the end tag are dropped until the next start mark.
// Path: the end tag passes the input register, then the parse update loads
// the output register and raises out_valid_o; an output stall holds the
// end tag in the input register until the output register is free.
// Throughput: 1 byte per cycle while the output is not stalled; the parse
// state update is a single small step per byte.
// Stall: when the output register is full and stalled, the input register
// holds and in_stall_o rises, one item of buffering on the input side.
// Reset: asynchronous, clears the parse state, captured values and both
// valid flags.
// ----------------------------------------------------------------------------
module dhcp_option_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opt_byte_i,
  input  logic        start_of_options_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  message_type_o,
  output logic [31:0] subnet_mask_o,
  output logic [31:0] router_address_o,
  output logic [31:0] server_identifier_o,
  output logic [31:0] lease_seconds_o,
  output logic [3:0]  found_flags_o
);

  localparam int unsigned IW = dox_pkg::IDX_W;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;

  // parse state
  dox_pkg::phase_e phase_q, phase_d;
  logic [1:0]  hcount_q, hcount_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  left_q, left_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [3:0]  seen_q, seen_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] mask_q, mask_d;
  logic [31:0] router_q, router_d;
  logic [31:0] server_q, server_d;
  logic [31:0] lease_q, lease_d;
  logic        emit;

  // output register
  logic        out_valid_q;

  logic out_free;
  logic advance;

  // effective state after an optional start mark
  dox_pkg::phase_e ph_e;
  logic [1:0]  hc_e;
  logic [7:0]  tag_e;
  logic [7:0]  left_e;
  logic [IW-1:0] idx_e;
  logic [3:0]  seen_e;

  function automatic logic [31:0] put_addr(input logic [31:0] r,
                                           input logic [IW-1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] res;
    res = r;
    if (idx < IW'(dox_pkg::ADDR_BYTES)) begin
      unique case (idx[1:0])
        2'd0:    res[31:24] = b;
        2'd1:    res[23:16] = b;
        2'd2:    res[15:8]  = b;
        default: res[7:0]   = b;
      endcase
    end
    return res;
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q  <= opt_byte_i;
      s1_start_q <= start_of_options_i;
    end
  end

  always_comb begin
    if (s1_start_q) begin
      ph_e   = dox_pkg::PH_HEADER;
      hc_e   = '0;
      tag_e  = '0;
      left_e = '0;
      idx_e  = '0;
      seen_e = '0;
    end else begin
      ph_e   = phase_q;
      hc_e   = hcount_q;
      tag_e  = tag_q;
      left_e = left_q;
      idx_e  = idx_q;
      seen_e = seen_q;
    end

    phase_d  = ph_e;
    hcount_d = hc_e;
    tag_d    = tag_e;
    left_d   = left_e;
    idx_d    = idx_e;
    seen_d   = seen_e;
    type_d   = type_q;
    mask_d   = mask_q;
    router_d = router_q;
    server_d = server_q;
    lease_d  = lease_q;
    emit     = 1'b0;

    unique case (ph_e)
      dox_pkg::PH_HEADER: begin
        if (hc_e >= 2'(dox_pkg::HEADER_SKIP - 1)) begin
          type_d  = s1_byte_q;
          phase_d = dox_pkg::PH_TAG;
        end else begin
          hcount_d = hc_e + 2'd1;
        end
      end
      dox_pkg::PH_TAG: begin
        if (s1_byte_q == dox_pkg::TAG_END) begin
          phase_d = dox_pkg::PH_DONE;
          emit    = 1'b1;
        end else begin
          tag_d   = s1_byte_q;
          phase_d = dox_pkg::PH_LEN;
          if (s1_byte_q == dox_pkg::TAG_MASK)
            seen_d[dox_pkg::FLAG_MASK] = 1'b1;
          else if (s1_byte_q == dox_pkg::TAG_ROUTER)
            seen_d[dox_pkg::FLAG_ROUTER] = 1'b1;
          else if (s1_byte_q == dox_pkg::TAG_SERVER)
            seen_d[dox_pkg::FLAG_SERVER] = 1'b1;
          else if (s1_byte_q == dox_pkg::TAG_LEASE)
            seen_d[dox_pkg::FLAG_LEASE] = 1'b1;
        end
      end
      dox_pkg::PH_LEN: begin
        idx_d = '0;
        if (tag_e == dox_pkg::TAG_LEASE) begin
          lease_d = '0;
          // zero-length lease still eats one value byte
          left_d  = (s1_byte_q == 8'd0) ? 8'd1 : s1_byte_q;
        end else begin
          left_d  = s1_byte_q;
        end
        phase_d = (left_d == 8'd0) ? dox_pkg::PH_TAG : dox_pkg::PH_VALUE;
      end
      dox_pkg::PH_VALUE: begin
        if (tag_e == dox_pkg::TAG_MASK)
          mask_d = put_addr(mask_q, idx_e, s1_byte_q);
        else if (tag_e == dox_pkg::TAG_ROUTER)
          router_d = put_addr(router_q, idx_e, s1_byte_q);
        else if (tag_e == dox_pkg::TAG_SERVER)
          server_d = put_addr(server_q, idx_e, s1_byte_q);
        else if (tag_e == dox_pkg::TAG_LEASE)
          lease_d = {lease_q[23:0], s1_byte_q};
        // index only matters up to ADDR_BYTES, so it saturates there
        if (idx_e != IW'(dox_pkg::ADDR_BYTES)) begin
          idx_d = idx_e + IW'(1);
        end
        left_d = left_e - 8'd1;
        if (left_d == 8'd0) begin
          phase_d = dox_pkg::PH_TAG;
        end
      end
      dox_pkg::PH_DONE: begin
        phase_d = dox_pkg::PH_DONE;
      end
      default: begin
        phase_d = dox_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= dox_pkg::PH_HEADER;
      hcount_q <= '0;
      tag_q    <= '0;
      left_q   <= '0;
      idx_q    <= '0;
      seen_q   <= '0;
      type_q   <= '0;
      mask_q   <= '0;
      router_q <= '0;
      server_q <= '0;
      lease_q  <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      hcount_q <= hcount_d;
      tag_q    <= tag_d;
      left_q   <= left_d;
      idx_q    <= idx_d;
      seen_q   <= seen_d;
      type_q   <= type_d;
      mask_q   <= mask_d;
      router_q <= router_d;
      server_q <= server_d;
      lease_q  <= lease_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      message_type_o      <= type_q;
      subnet_mask_o       <= mask_q;
      router_address_o    <= router_q;
      server_identifier_o <= server_q;
      lease_seconds_o     <= lease_q;
      found_flags_o       <= seen_e;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/dox_checker.sv
// ----------------------------------------------------------------------------
// dox_checker
// Port-level checks for the DHCP option extractor, bound to the top level.
// ----------------------------------------------------------------------------
module dox_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  message_type_o,
  input logic [31:0] lease_seconds_o,
  input logic [3:0]  found_flags_o
);

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(message_type_o) && $stable(lease_seconds_o) && $stable(found_flags_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled, full output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // a fresh result traces back to an accepted input item
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching item");

endmodule

bind dhcp_option_extractor dox_checker u_dox_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .message_type_o  (message_type_o),
  .lease_seconds_o (lease_seconds_o),
  .found_flags_o   (found_flags_o)
);
